// File: design/pese_pkg.sv
// shared types and constants for the prefix expression stack evaluator
// no dependencies, used by pese_alu and the top level
`default_nettype none

package pese_pkg;

    // value and field widths
    localparam int DATA_W      = 32;
    localparam int NUMBER_W    = 31;
    localparam int OP_W        = 3;
    localparam int S_TDATA_W   = 40;
    localparam int M_TDATA_W   = 32;
    localparam int FLAGS_W     = 4;

    // input tdata layout
    localparam int NUMBER_LSB  = 0;
    localparam int OP_LSB      = NUMBER_W;

    // divider sequencing
    localparam int DIV_STEPS   = DATA_W;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

    // value taken for an empty pop, or emitted for an aborted expression
    localparam logic [DATA_W-1:0] MINUS_ONE = '1;

    typedef enum logic {
        KIND_NUMBER   = 1'b0,
        KIND_OPERATOR = 1'b1
    } token_kind_t;

    // codes four to seven are invalid operators
    typedef enum logic [OP_W-1:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3
    } op_code_t;

    // sticky flags, overflow in the lowest bit
    typedef struct packed {
        logic bad;
        logic div0;
        logic unf;
        logic ovf;
    } flags_t;

    typedef struct packed {
        logic     start;
        op_code_t op;
    } alu_req_t;

    typedef struct packed {
        logic done;
        logic div0;
    } alu_rsp_t;

    typedef enum logic [1:0] {
        A_IDLE,
        A_DIV,
        A_FIX
    } alu_state_t;

    typedef enum logic [1:0] {
        POP_A,
        POP_B,
        POP_RES
    } pop_sel_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PUSH,
        S_POP,
        S_POP_WAIT,
        S_EXEC,
        S_ALU_WAIT,
        S_FINAL,
        S_EMIT
    } state_t;

endpackage

`default_nettype wire

// File: design/pese_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module pese_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: design/pese_alu.sv
// shared arithmetic unit: add, subtract, multiply in one step, divide one bit a cycle
// depends on pese_pkg
`default_nettype none

module pese_alu (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire pese_pkg::alu_req_t            req,
    input  wire logic [pese_pkg::DATA_W-1:0]   opa,
    input  wire logic [pese_pkg::DATA_W-1:0]   opb,
    output pese_pkg::alu_rsp_t                 rsp,
    output logic      [pese_pkg::DATA_W-1:0]   result
);

    localparam int W = pese_pkg::DATA_W;

    pese_pkg::alu_state_t            state_reg, state_next;
    logic [pese_pkg::DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [W-1:0]                    rem_reg, rem_next;
    logic [W-1:0]                    quo_reg, quo_next;
    logic [W-1:0]                    dvs_reg, dvs_next;
    logic                            neg_reg, neg_next;
    logic [W-1:0]                    res_reg, res_next;
    logic                            done_reg, done_next;
    logic                            div0_reg, div0_next;

    logic [W-1:0] mag_a, mag_b, product;
    logic [W:0]   shifted, trial;

    // magnitudes of the operands; the most negative value maps to 2^31
    assign mag_a   = opa[W-1] ? (W'(0) - opa) : opa;
    assign mag_b   = opb[W-1] ? (W'(0) - opb) : opb;
    assign product = opa * opb;

    // restoring division step
    assign shifted = {rem_reg, quo_reg[W-1]};
    assign trial   = shifted - {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pese_pkg::A_IDLE;
            done_reg  <= 1'b0;
            div0_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
            div0_reg  <= div0_next;
        end
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
        res_reg <= res_next;
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        dvs_next   = dvs_reg;
        neg_next   = neg_reg;
        res_next   = res_reg;
        done_next  = 1'b0;
        div0_next  = 1'b0;
        case (state_reg)
            pese_pkg::A_IDLE: begin
                if (req.start) begin
                    case (req.op)
                        pese_pkg::OP_ADD: begin
                            res_next  = opa + opb;
                            done_next = 1'b1;
                        end
                        pese_pkg::OP_SUB: begin
                            res_next  = opa - opb;
                            done_next = 1'b1;
                        end
                        pese_pkg::OP_MUL: begin
                            res_next  = product;
                            done_next = 1'b1;
                        end
                        pese_pkg::OP_DIV: begin
                            if (mag_b == '0) begin
                                res_next  = '0;
                                done_next = 1'b1;
                                div0_next = 1'b1;
                            end else begin
                                rem_next   = '0;
                                quo_next   = mag_a;
                                dvs_next   = mag_b;
                                neg_next   = opa[W-1] ^ opb[W-1];
                                cnt_next   = '0;
                                state_next = pese_pkg::A_DIV;
                            end
                        end
                        default: begin
                            res_next  = '0;
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            pese_pkg::A_DIV: begin
                if (!trial[W]) begin
                    rem_next = trial[W-1:0];
                    quo_next = {quo_reg[W-2:0], 1'b1};
                end else begin
                    rem_next = shifted[W-1:0];
                    quo_next = {quo_reg[W-2:0], 1'b0};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == pese_pkg::DIV_CNT_W'(pese_pkg::DIV_STEPS - 1)) begin
                    state_next = pese_pkg::A_FIX;
                end
            end
            pese_pkg::A_FIX: begin
                // sign fix-up, truncation toward zero
                res_next   = neg_reg ? (W'(0) - quo_reg) : quo_reg;
                done_next  = 1'b1;
                state_next = pese_pkg::A_IDLE;
            end
            default: begin
                state_next = pese_pkg::A_IDLE;
            end
        endcase
    end

    assign rsp.done = done_reg;
    assign rsp.div0 = div0_reg;
    assign result   = res_reg;

endmodule

`default_nettype wire

// File: design/prefix_expression_stack_evaluator.sv
// top level: token sequencer, value stack in ram and the shared arithmetic unit
// depends on pese_pkg, pese_ram and pese_alu
// a number token is pushed; an operator pops two operands, runs the arithmetic unit and pushes
// the result (the divider retires one quotient bit a cycle); a last token adds the final pop
// throughput: one token at a time, s_axis_tready is high only between tokens
// reset: aresetn synchronous active low, empties the stack and clears the flags; no clearing pass
`default_nettype none

module prefix_expression_stack_evaluator #(
    parameter int STACK_DEPTH = 128
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // token input channel
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // tdata: token_number [30:0], operator_code [33:31], zero [39:34]
    input  wire logic [pese_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // tuser: token_kind
    input  wire logic                             s_axis_tuser,
    input  wire logic                             s_axis_tlast,
    // result channel
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // tdata: result_value [31:0]
    output logic      [pese_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    // tuser: overflow_seen, underflow_seen, divide_by_zero_seen, bad_operator_seen
    output logic      [pese_pkg::FLAGS_W-1:0]     m_axis_tuser
);

    localparam int W      = pese_pkg::DATA_W;
    localparam int ADDR_W = $clog2(STACK_DEPTH);
    localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);

    // sequencer and stack control
    pese_pkg::state_t                 state_reg, state_next;
    pese_pkg::pop_sel_t               pop_sel_reg, pop_sel_next;
    logic [DEPTH_W-1:0]               depth_reg, depth_next;
    pese_pkg::flags_t                 flags_reg, flags_next;

    // latched token
    pese_pkg::op_code_t               op_reg, op_next;
    logic                             last_reg, last_next;

    // operands and values in flight
    logic [W-1:0]                     opa_reg, opa_next;
    logic [W-1:0]                     opb_reg, opb_next;
    logic [W-1:0]                     push_reg, push_next;
    logic [W-1:0]                     res_reg, res_next;

    // output register, parts the result channel from the sequencer
    logic                             out_valid_reg, out_valid_next;
    logic [W-1:0]                     out_data_reg, out_data_next;
    pese_pkg::flags_t                 out_flags_reg, out_flags_next;

    // stack ram ports
    logic                             ram_wr_en, ram_rd_en;
    logic [ADDR_W-1:0]                ram_wr_addr, ram_rd_addr;
    logic [W-1:0]                     ram_rd_data;
    logic [DEPTH_W-1:0]               depth_dec;
    logic                             stack_full, out_free;

    pese_pkg::alu_req_t               alu_req;
    pese_pkg::alu_rsp_t               alu_rsp;
    logic [W-1:0]                     alu_result;

    pese_ram #(
        .WIDTH (W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (push_reg),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    pese_alu u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (alu_req),
        .opa     (opa_reg),
        .opb     (opb_reg),
        .rsp     (alu_rsp),
        .result  (alu_result)
    );

    assign depth_dec   = depth_reg - 1'b1;
    assign stack_full  = (depth_reg == DEPTH_W'(STACK_DEPTH));
    assign out_free    = !out_valid_reg || m_axis_tready;
    // push writes the top free slot, pop reads the one below the depth
    assign ram_wr_addr = depth_reg[ADDR_W-1:0];
    assign ram_rd_addr = depth_dec[ADDR_W-1:0];

    assign s_axis_tready = (state_reg == pese_pkg::S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_flags_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= pese_pkg::S_IDLE;
            depth_reg     <= '0;
            flags_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            depth_reg     <= depth_next;
            flags_reg     <= flags_next;
            out_valid_reg <= out_valid_next;
        end
        pop_sel_reg   <= pop_sel_next;
        op_reg        <= op_next;
        last_reg      <= last_next;
        opa_reg       <= opa_next;
        opb_reg       <= opb_next;
        push_reg      <= push_next;
        res_reg       <= res_next;
        out_data_reg  <= out_data_next;
        out_flags_reg <= out_flags_next;
    end

    always_comb begin
        state_next     = state_reg;
        pop_sel_next   = pop_sel_reg;
        depth_next     = depth_reg;
        flags_next     = flags_reg;
        op_next        = op_reg;
        last_next      = last_reg;
        opa_next       = opa_reg;
        opb_next       = opb_reg;
        push_next      = push_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_flags_next = out_flags_reg;
        ram_wr_en      = 1'b0;
        ram_rd_en      = 1'b0;
        alu_req.start  = 1'b0;
        alu_req.op     = op_reg;

        // result channel drains independently of the sequencer
        if (out_valid_reg && m_axis_tready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            pese_pkg::S_IDLE: begin
                if (s_axis_tvalid) begin
                    op_next   = pese_pkg::op_code_t'(
                                    s_axis_tdata[pese_pkg::OP_LSB +: pese_pkg::OP_W]);
                    last_next = s_axis_tlast;
                    push_next = {1'b0, s_axis_tdata[pese_pkg::NUMBER_LSB +: pese_pkg::NUMBER_W]};
                    if (flags_reg.bad) begin
                        // aborted expression: tokens are swallowed up to the last one
                        state_next = s_axis_tlast ? pese_pkg::S_FINAL : pese_pkg::S_IDLE;
                    end else if (s_axis_tuser == pese_pkg::KIND_NUMBER) begin
                        state_next = pese_pkg::S_PUSH;
                    end else begin
                        pop_sel_next = pese_pkg::POP_A;
                        state_next   = pese_pkg::S_POP;
                    end
                end
            end
            pese_pkg::S_PUSH: begin
                // full stack drops the value
                if (stack_full) begin
                    flags_next.ovf = 1'b1;
                end else begin
                    ram_wr_en  = 1'b1;
                    depth_next = depth_reg + 1'b1;
                end
                state_next = last_reg ? pese_pkg::S_FINAL : pese_pkg::S_IDLE;
            end
            pese_pkg::S_POP: begin
                if (depth_reg == '0) begin
                    // empty stack pops minus one
                    flags_next.unf = 1'b1;
                    case (pop_sel_reg)
                        pese_pkg::POP_A: begin
                            opa_next     = pese_pkg::MINUS_ONE;
                            pop_sel_next = pese_pkg::POP_B;
                            state_next   = pese_pkg::S_POP;
                        end
                        pese_pkg::POP_B: begin
                            opb_next   = pese_pkg::MINUS_ONE;
                            state_next = pese_pkg::S_EXEC;
                        end
                        default: begin
                            res_next   = pese_pkg::MINUS_ONE;
                            state_next = pese_pkg::S_EMIT;
                        end
                    endcase
                end else begin
                    ram_rd_en  = 1'b1;
                    depth_next = depth_dec;
                    state_next = pese_pkg::S_POP_WAIT;
                end
            end
            pese_pkg::S_POP_WAIT: begin
                // registered read data lands here
                case (pop_sel_reg)
                    pese_pkg::POP_A: begin
                        opa_next     = ram_rd_data;
                        pop_sel_next = pese_pkg::POP_B;
                        state_next   = pese_pkg::S_POP;
                    end
                    pese_pkg::POP_B: begin
                        opb_next   = ram_rd_data;
                        state_next = pese_pkg::S_EXEC;
                    end
                    default: begin
                        res_next   = ram_rd_data;
                        state_next = pese_pkg::S_EMIT;
                    end
                endcase
            end
            pese_pkg::S_EXEC: begin
                case (op_reg)
                    pese_pkg::OP_ADD,
                    pese_pkg::OP_SUB,
                    pese_pkg::OP_MUL,
                    pese_pkg::OP_DIV: begin
                        alu_req.start = 1'b1;
                        state_next    = pese_pkg::S_ALU_WAIT;
                    end
                    default: begin
                        // invalid operator: operands already popped, nothing pushed
                        flags_next.bad = 1'b1;
                        state_next     = last_reg ? pese_pkg::S_FINAL : pese_pkg::S_IDLE;
                    end
                endcase
            end
            pese_pkg::S_ALU_WAIT: begin
                if (alu_rsp.done) begin
                    push_next = alu_result;
                    if (alu_rsp.div0) begin
                        flags_next.div0 = 1'b1;
                    end
                    state_next = pese_pkg::S_PUSH;
                end
            end
            pese_pkg::S_FINAL: begin
                if (flags_reg.bad) begin
                    res_next   = pese_pkg::MINUS_ONE;
                    state_next = pese_pkg::S_EMIT;
                end else begin
                    pop_sel_next = pese_pkg::POP_RES;
                    state_next   = pese_pkg::S_POP;
                end
            end
            pese_pkg::S_EMIT: begin
                // hand the result over once the output register is free, then start afresh
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg;
                    out_flags_next = flags_reg;
                    depth_next     = '0;
                    flags_next     = '0;
                    state_next     = pese_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = pese_pkg::S_IDLE;
            end
        endcase
    end

    // the stack never holds more than its depth
    assert property (@(posedge aclk) disable iff (!aresetn)
        depth_reg <= DEPTH_W'(STACK_DEPTH))
        else $error("stack depth beyond capacity");

    // a write only ever lands on a free slot
    assert property (@(posedge aclk) disable iff (!aresetn)
        ram_wr_en |-> !stack_full)
        else $error("stack write while full");

    // arithmetic results only arrive while the sequencer waits for them
    assert property (@(posedge aclk) disable iff (!aresetn)
        alu_rsp.done |-> (state_reg == pese_pkg::S_ALU_WAIT))
        else $error("unexpected arithmetic completion");

    // the abort flag is sticky until the result is handed over
    assert property (@(posedge aclk) disable iff (!aresetn)
        (flags_reg.bad && state_reg != pese_pkg::S_EMIT) |=> flags_reg.bad)
        else $error("abort flag lost before emit");

    // emitting a result leaves an empty stack and clear flags
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == pese_pkg::S_EMIT && out_free) |=> (depth_reg == '0 && flags_reg == '0))
        else $error("stack not cleared after emit");

endmodule

`default_nettype wire
